### hdl/gjd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and lookup functions for the Gregorian to Jalali
// date unit. No dependencies.
package gjd_pkg;

  localparam int unsigned DAY_W = 20;

  localparam logic [11:0] YEAR_FLOOR   = 12'd1601;
  localparam logic [11:0] EPOCH_YEAR   = 12'd1600;
  localparam logic [11:0] JALALI_BASE  = 12'd979;
  localparam logic [DAY_W-1:0] EPOCH_OFFSET = 20'd79;

  localparam logic [8:0] YEAR_DAYS      = 9'd365;
  localparam logic [8:0] LEAP_YEAR_DAYS = 9'd366;

  // floor(x / 100) = (x * C100_MUL) >> C100_SHIFT for x < 4096
  localparam logic [12:0] C100_MUL   = 13'd5243;
  localparam int unsigned C100_SHIFT = 19;

  // 33-year cycle split, exact for 20-bit counts
  localparam logic [13:0] CYCLE_DAYS  = 14'd12053;
  localparam logic [20:0] CYCLE_MUL   = 21'd1425361;
  localparam int unsigned CYCLE_SHIFT = 34;

  // 4-year group split, exact for 14-bit counts
  localparam logic [10:0] GROUP_DAYS  = 11'd1461;
  localparam logic [14:0] GROUP_MUL   = 15'd22967;
  localparam int unsigned GROUP_SHIFT = 25;

  typedef struct packed {
    logic [11:0] year;
    logic [8:0]  doy;
  } ydoy_t;

  // Days of a common Gregorian year before each month; index 12 is the full year.
  function automatic logic [8:0] greg_before(input logic [3:0] mi);
    logic [8:0] d;
    case (mi)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

  // Day of the Jalali year on which each month (0 = Farvardin) starts.
  function automatic logic [8:0] jal_start(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd62;
      4'd3:    d = 9'd93;
      4'd4:    d = 9'd124;
      4'd5:    d = 9'd155;
      4'd6:    d = 9'd186;
      4'd7:    d = 9'd216;
      4'd8:    d = 9'd246;
      4'd9:    d = 9'd276;
      4'd10:   d = 9'd306;
      default: d = 9'd336;
    endcase
    return d;
  endfunction

endpackage

### hdl/gregorian_to_jalali_date_unit.sv
`timescale 1ns / 1ps
// Gregorian to Jalali date converter, top level.
// Depends on gjd_pkg, gjd_days, gjd_cycle and gjd_month.
//
// Usage:
//   Input channel: in_valid/in_ready with greg_year, greg_month, greg_day.
//   Output channel: out_valid/out_ready with jalali_year, jalali_month,
//   jalali_day. One result per input transfer, in input order.
//   Pipeline: an input transfer reaches out_valid through nine
//   register stages: three for the day count, five for the cycle, group
//   and year split (each reciprocal multiply is followed by a register
//   before its remainder multiply), one for the month lookup and output.
//   Throughput: one date per cycle while out_ready stays high.
//   Stall: when out_ready is low, the output holds and stages upstream
//   keep filling until full; in_ready drops only when every stage holds a
//   date. Empty stages are squeezed out, so bubbles cost no throughput.
//   Reset: rst (synchronous) clears all stage valid bits; nothing is lost
//   but dates in flight. Inputs are not range checked: years below 1601
//   are taken as 1601, out-of-range months and days follow the day count.
module gregorian_to_jalali_date_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] greg_year,
  input  logic [3:0]  greg_month,
  input  logic [4:0]  greg_day,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] jalali_year,
  output logic [3:0]  jalali_month,
  output logic [4:0]  jalali_day
);
  import gjd_pkg::*;

  logic             days_valid, days_ready;
  logic [DAY_W-1:0] days_count;
  logic             cyc_valid, cyc_ready;
  ydoy_t            cyc_result;

  gjd_days u_days (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .year      (greg_year),
    .month     (greg_month),
    .day       (greg_day),
    .out_valid (days_valid),
    .out_ready (days_ready),
    .count     (days_count)
  );

  gjd_cycle u_cycle (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (days_valid),
    .in_ready  (days_ready),
    .count     (days_count),
    .out_valid (cyc_valid),
    .out_ready (cyc_ready),
    .result    (cyc_result)
  );

  gjd_month u_month (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cyc_valid),
    .in_ready  (cyc_ready),
    .ydoy      (cyc_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .year      (jalali_year),
    .month     (jalali_month),
    .day       (jalali_day)
  );

`ifndef NO_ASSERTIONS
  a_no_valid_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (jalali_month >= 4'd1) && (jalali_month <= 4'd12))
    else $error("jalali_month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (jalali_day >= 5'd1)
                  && ((jalali_month <= 4'd6) || (jalali_day <= 5'd30)))
    else $error("jalali_day out of range for its month");

  a_year_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (jalali_year >= JALALI_BASE))
    else $error("jalali_year below base year");
`endif

endmodule

### hdl/gjd_days.sv
`timescale 1ns / 1ps
// Day count since the calendar epoch from a Gregorian date, three stages.
// Depends on gjd_pkg.
module gjd_days (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [11:0]                 year,
  input  logic [3:0]                  month,
  input  logic [4:0]                  day,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gjd_pkg::DAY_W-1:0]   count
);
  import gjd_pkg::*;

  logic va, vb, vc;
  logic en_a, en_b, en_c;

  logic [11:0] gy;
  logic [3:0]  mi;
  logic [4:0]  dy;
  logic        late;

  logic [DAY_W-1:0] base, base_next;
  logic [4:0]       c100, c100_next;
  logic [23:0]      c100_prod;
  logic [11:0]      gyb;
  logic             late_b;

  logic             cent, leap;
  logic [4:0]       c400;
  logic [DAY_W-1:0] count_next;

  assign en_c     = !vc || out_ready;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;
  assign out_valid = vc;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
    end
  end

  // stage A: clamp and normalize
  always_ff @(posedge clk) begin
    if (en_a) begin
      gy   <= (year < YEAR_FLOOR) ? 12'd1 : year - EPOCH_YEAR;
      mi   <= (month == 4'd0) ? 4'd0 : ((month > 4'd12) ? 4'd12 : month - 4'd1);
      dy   <= day;
      late <= month > 4'd2;
    end
  end

  // stage B: linear terms and century count
  assign base_next = DAY_W'(gy) * DAY_W'(YEAR_DAYS)
                   + DAY_W'((gy + 12'd3) >> 2)
                   + DAY_W'(greg_before(mi))
                   + DAY_W'(dy);
  assign c100_prod = 24'(gy + 12'd99) * 24'(C100_MUL);
  assign c100_next = c100_prod[C100_SHIFT +: 5];

  always_ff @(posedge clk) begin
    if (en_b) begin
      base   <= base_next;
      c100   <= c100_next;
      gyb    <= gy;
      late_b <= late;
    end
  end

  // stage C: century corrections, leap day, epoch offset
  assign cent = (12'(c100) * 12'd100) == gyb;
  assign leap = late_b && (gyb[1:0] == 2'b00) && (!cent || (c100[1:0] == 2'b00));
  assign c400 = (c100 + 5'd3) >> 2;
  assign count_next = base - DAY_W'(c100) + DAY_W'(c400) + DAY_W'(leap)
                    - EPOCH_OFFSET - DAY_W'(1);

  always_ff @(posedge clk) begin
    if (en_c) count <= count_next;
  end

endmodule

### hdl/gjd_cycle.sv
`timescale 1ns / 1ps
// Splits the day count into 33-year cycles, 4-year groups and years,
// five stages. Depends on gjd_pkg.
module gjd_cycle (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gjd_pkg::DAY_W-1:0]   count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gjd_pkg::ydoy_t              result
);
  import gjd_pkg::*;

  logic vd, ve, vf, vg, vh;
  logic en_d, en_e, en_f, en_g, en_h;

  logic [40:0]      prod33;
  logic [6:0]       q33_d;
  logic [DAY_W-1:0] cnt_d;

  logic [13:0] r33_e, r33_next;
  logic [11:0] y33_e, y33_next;

  logic [28:0] prod4;
  logic [3:0]  q4_f;
  logic [13:0] r33_f;
  logic [11:0] y33_f;

  logic [10:0] r4_g, r4_next;
  logic [11:0] y4_g, y4_next;

  logic [10:0] t;
  logic [1:0]  k;
  logic [10:0] doy_wide;
  ydoy_t       result_next;

  assign en_h      = !vh || out_ready;
  assign en_g      = !vg || en_h;
  assign en_f      = !vf || en_g;
  assign en_e      = !ve || en_f;
  assign en_d      = !vd || en_e;
  assign in_ready  = en_d;
  assign out_valid = vh;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
      vh <= 1'b0;
    end else begin
      if (en_d) vd <= in_valid;
      if (en_e) ve <= vd;
      if (en_f) vf <= ve;
      if (en_g) vg <= vf;
      if (en_h) vh <= vg;
    end
  end

  // stage D: cycle quotient by reciprocal
  assign prod33 = 41'(count) * 41'(CYCLE_MUL);

  always_ff @(posedge clk) begin
    if (en_d) begin
      q33_d <= prod33[CYCLE_SHIFT +: 7];
      cnt_d <= count;
    end
  end

  // stage E: cycle remainder and base year
  assign r33_next = 14'(cnt_d - DAY_W'(q33_d) * DAY_W'(CYCLE_DAYS));
  assign y33_next = JALALI_BASE + 12'(q33_d) * 12'd33;

  always_ff @(posedge clk) begin
    if (en_e) begin
      r33_e <= r33_next;
      y33_e <= y33_next;
    end
  end

  // stage F: group quotient by reciprocal
  assign prod4 = 29'(r33_e) * 29'(GROUP_MUL);

  always_ff @(posedge clk) begin
    if (en_f) begin
      q4_f  <= prod4[GROUP_SHIFT +: 4];
      r33_f <= r33_e;
      y33_f <= y33_e;
    end
  end

  // stage G: group remainder
  assign r4_next = 11'(r33_f - 14'(q4_f) * 14'(GROUP_DAYS));
  assign y4_next = y33_f + 12'({q4_f, 2'b00});

  always_ff @(posedge clk) begin
    if (en_g) begin
      r4_g <= r4_next;
      y4_g <= y4_next;
    end
  end

  // stage H: year within group; first year of a group is the long one
  assign t = r4_g - 11'd1;

  always_comb begin
    if (r4_g < 11'(LEAP_YEAR_DAYS)) begin
      k = 2'd0;
    end else if (t >= 11'(YEAR_DAYS) * 11'd3) begin
      k = 2'd3;
    end else if (t >= 11'(YEAR_DAYS) * 11'd2) begin
      k = 2'd2;
    end else begin
      k = 2'd1;
    end
  end

  assign doy_wide = (k == 2'd0) ? r4_g : t - 11'(k) * 11'(YEAR_DAYS);
  assign result_next.year = y4_g + 12'(k);
  assign result_next.doy  = doy_wide[8:0];

  always_ff @(posedge clk) begin
    if (en_h) result <= result_next;
  end

endmodule

### hdl/gjd_month.sv
`timescale 1ns / 1ps
// Jalali month and day from the day of the year, output register stage.
// Depends on gjd_pkg.
module gjd_month (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gjd_pkg::ydoy_t ydoy,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [11:0]    year,
  output logic [3:0]     month,
  output logic [4:0]     day
);
  import gjd_pkg::*;

  logic       vi, en_i;
  logic [3:0] idx;
  logic [8:0] rem;

  assign en_i      = !vi || out_ready;
  assign in_ready  = en_i;
  assign out_valid = vi;

  always_comb begin
    idx = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (ydoy.doy >= jal_start(4'(i))) idx = 4'(i);
    end
  end

  assign rem = ydoy.doy - jal_start(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      vi <= 1'b0;
    end else if (en_i) begin
      vi <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      year  <= ydoy.year;
      month <= idx + 4'd1;
      day   <= rem[4:0] + 5'd1;
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for gregorian_to_jalali_date_unit: directed and random
// dates, a local calendar predictor, random input gaps and output stalls.
// Depends on the RTL top level only.
module tb_top;

  localparam int unsigned GREG_YEAR_MIN = 1601;
  localparam int unsigned GREG_EPOCH    = 1600;
  localparam int unsigned EPOCH_SHIFT   = 79;
  localparam int unsigned CYCLE33_LEN   = 12053;
  localparam int unsigned GROUP4_LEN    = 1461;
  localparam int unsigned JALALI_FIRST  = 979;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES  = 20;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } jalali_date_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] greg_year = '0;
  logic [3:0]  greg_month = '0;
  logic [4:0]  greg_day = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] jalali_year;
  logic [3:0]  jalali_month;
  logic [4:0]  jalali_day;

  jalali_date_t pending_jalali[$];
  int unsigned  errors = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  burst_left = 0;
  bit           tx_no_gaps = 1'b0;
  bit           rx_free_run = 1'b0;
  logic [7:0]   rx_count = '0;
  logic [15:0]  rx_pattern = 16'hFFFF;

  gregorian_to_jalali_date_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .greg_year    (greg_year),
    .greg_month   (greg_month),
    .greg_day     (greg_day),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .jalali_year  (jalali_year),
    .jalali_month (jalali_month),
    .jalali_day   (jalali_day)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit is_greg_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned days_before_month(input int unsigned mi);
    int unsigned d;
    case (mi)
      0:       d = 0;
      1:       d = 31;
      2:       d = 59;
      3:       d = 90;
      4:       d = 120;
      5:       d = 151;
      6:       d = 181;
      7:       d = 212;
      8:       d = 243;
      9:       d = 273;
      10:      d = 304;
      11:      d = 334;
      default: d = 365;
    endcase
    return d;
  endfunction

  function automatic int unsigned jalali_month_len(input int unsigned m);
    if (m < 6) return 31;
    if (m < 11) return 30;
    return 29;
  endfunction

  function automatic int unsigned greg_month_len(input int unsigned y, input int unsigned m);
    if (m == 2) return is_greg_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic jalali_date_t predict_jalali(input logic [11:0] y, input logic [3:0] m,
                                                  input logic [4:0] d);
    int unsigned yr, gy, mi, cnt, jy, jm;
    jalali_date_t r;
    yr = y;
    if (yr < GREG_YEAR_MIN) yr = GREG_YEAR_MIN;
    gy = yr - GREG_EPOCH;
    mi = (m == 0) ? 0 : m - 1;
    if (mi > 12) mi = 12;
    cnt = 365 * gy + (gy + 3) / 4 - (gy + 99) / 100 + (gy + 399) / 400;
    cnt += days_before_month(mi);
    if (m > 2 && is_greg_leap(yr)) cnt += 1;
    cnt = cnt + d - 1 - EPOCH_SHIFT;
    jy = JALALI_FIRST + 33 * (cnt / CYCLE33_LEN);
    cnt = cnt % CYCLE33_LEN;
    jy += 4 * (cnt / GROUP4_LEN);
    cnt = cnt % GROUP4_LEN;
    if (cnt >= 366) begin
      jy += (cnt - 1) / 365;
      cnt = (cnt - 1) % 365;
    end
    jm = 0;
    while (jm < 11 && cnt >= jalali_month_len(jm)) begin
      cnt -= jalali_month_len(jm);
      jm++;
    end
    r.year  = jy[11:0];
    r.month = 4'(jm + 1);
    r.day   = 5'(cnt + 1);
    return r;
  endfunction

  // Receiver: a new ready pattern is picked each time the 8-bit rx_count wraps to zero.
  always @(posedge clk) begin
    rx_count = rx_count + 8'd1;
    if (rx_count == 8'd0) begin
      case ($urandom_range(0, 3))
        0:       rx_pattern = 16'hFFFF;
        1:       rx_pattern = 16'($urandom);
        2:       rx_pattern = 16'($urandom & $urandom & $urandom) | 16'h0001;
        default: rx_pattern = 16'($urandom) | 16'h0101;
      endcase
    end
    out_ready <= rx_free_run ? 1'b1 : rx_pattern[rx_count[3:0]];
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    jalali_date_t exp_date;
    if (!rst && ((in_valid && in_ready) || (out_valid && out_ready)))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_jalali.size() == 0) begin
        $error("unexpected result transfer: year %0d month %0d day %0d",
               jalali_year, jalali_month, jalali_day);
        errors++;
      end else begin
        exp_date = pending_jalali.pop_front();
        if (jalali_year !== exp_date.year) begin
          $error("jalali_year: expected %0d, got %0d", exp_date.year, jalali_year);
          errors++;
        end
        if (jalali_month !== exp_date.month) begin
          $error("jalali_month: expected %0d, got %0d", exp_date.month, jalali_month);
          errors++;
        end
        if (jalali_day !== exp_date.day) begin
          $error("jalali_day: expected %0d, got %0d", exp_date.day, jalali_day);
          errors++;
        end
      end
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("gregorian_to_jalali_date_unit: mismatch");
      $finish;
    end
  end

  // Called right after a rising edge; returns after the accepting edge and any gap.
  task automatic send_date(input logic [11:0] y, input logic [3:0] m, input logic [4:0] d);
    int unsigned gap;
    in_valid   <= 1'b1;
    greg_year  <= y;
    greg_month <= m;
    greg_day   <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_jalali.push_back(predict_jalali(y, m, d));
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!tx_no_gaps) gap = $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_jalali.size() != 0) @(posedge clk);
  endtask

  task automatic send_valid_date();
    int unsigned y, m;
    y = $urandom_range(GREG_YEAR_MIN, 3599);
    m = $urandom_range(1, 12);
    send_date(12'(y), 4'(m), 5'($urandom_range(1, greg_month_len(y, m))));
  endtask

  task automatic test_directed_dates();
    send_date(12'd1601, 4'd1, 5'd1);
    send_date(12'd3599, 4'd12, 5'd31);
    send_date(12'd0, 4'd0, 5'd0);
    send_date(12'd4095, 4'd15, 5'd31);
    send_date(12'd1600, 4'd6, 5'd15);
    send_date(12'd3600, 4'd3, 5'd1);
    send_date(12'd2000, 4'd2, 5'd29);
    send_date(12'd2000, 4'd3, 5'd1);
    send_date(12'd1900, 4'd2, 5'd28);
    send_date(12'd1900, 4'd3, 5'd1);
    send_date(12'd2024, 4'd3, 5'd19);
    send_date(12'd2024, 4'd3, 5'd20);
    send_date(12'd2025, 4'd3, 5'd21);
    send_date(12'd2023, 4'd12, 5'd31);
    send_date(12'd2024, 4'd12, 5'd31);
    send_date(12'd2023, 4'd2, 5'd31);
    send_date(12'd2024, 4'd5, 5'd0);
    send_date(12'd2024, 4'd13, 5'd1);
    send_date(12'd2023, 4'd14, 5'd20);
    send_date(12'd2022, 4'd9, 5'd22);
    send_date(12'd2022, 4'd9, 5'd23);
    send_date(12'd1979, 4'd2, 5'd11);
    send_date(12'd2100, 4'd3, 5'd20);
    send_date(12'd2400, 4'd3, 5'd20);
  endtask

  task automatic test_random_valid_dates(input int unsigned n);
    repeat (n) send_valid_date();
  endtask

  task automatic test_random_raw_fields(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 1))
        send_date(12'($urandom), 4'($urandom), 5'($urandom));
      else
        send_date(12'($urandom_range(GREG_YEAR_MIN, 4095)), 4'($urandom), 5'($urandom));
    end
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat ($urandom_range(10, 40)) send_valid_date();
      wait_all_results();
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic test_steady_stream(input int unsigned n);
    tx_no_gaps  = 1'b1;
    rx_free_run = 1'b1;
    repeat (n) send_valid_date();
    tx_no_gaps  = 1'b0;
    rx_free_run = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_dates();
    test_random_valid_dates(600);
    test_drain_pause();
    test_random_raw_fields(300);
    test_steady_stream(150);
    test_random_valid_dates(500);
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("gregorian_to_jalali_date_unit: match");
    else
      $display("gregorian_to_jalali_date_unit: mismatch");
    $finish;
  end

endmodule
